[rtl/tpm_pkg.sv]
// shared types, constants and helpers of the text pattern matcher
`default_nettype none

package tpm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int PAT_AW      = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 7;
    localparam int CHAR_W      = 8;
    localparam int COL_W       = 8;
    localparam int ACT_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 8;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TEXT  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_CASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_SEARCH = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]       pattern_length;
        logic [MAX_PATTERN-1:0] len_mask;
        logic [PAT_AW-1:0]      align_shift;
        logic                   len_ok;
        logic                   ignore_case;
        logic                   reverse_search;
    } cfg_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [PAT_AW-1:0] pattern_index;
        logic [CHAR_W-1:0] char_code;
        logic [COL_W-1:0]  column;
    } item_t;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic ic);
        logic [CHAR_W-1:0] r;
        r = c;
        if (ic && (c inside {[8'h41:8'h5A]})) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/tpm_cfg_regs.sv]
// configuration registers with precomputed length mask and alignment shift
`default_nettype none

module tpm_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    input  wire logic [tpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tpm_pkg::LEN_W-1:0]     cfg_data,
    output tpm_pkg::cfg_t                      cfg
);
    import tpm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic [MAX_PATTERN-1:0] mask_next;
    logic [LEN_W-1:0]       shift_wide;

    always_comb begin
        for (int p = 0; p < MAX_PATTERN; p++) begin
            mask_next[p] = (LEN_W'(p) < cfg_data);
        end
        shift_wide = LEN_W'(MAX_PATTERN) - cfg_data;
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_PATTERN_LENGTH: begin
                    cfg_next.pattern_length = cfg_data;
                    cfg_next.len_mask       = mask_next;
                    cfg_next.align_shift    = shift_wide[PAT_AW-1:0];
                    cfg_next.len_ok         = (cfg_data != '0) &&
                                              (cfg_data <= LEN_W'(MAX_PATTERN));
                end
                REG_IGNORE_CASE:    cfg_next.ignore_case    = cfg_data[0];
                REG_REVERSE_SEARCH: cfg_next.reverse_search = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_length <= LEN_W'(1);
            cfg_reg.len_mask       <= MAX_PATTERN'(1);
            cfg_reg.align_shift    <= PAT_AW'(MAX_PATTERN - 1);
            cfg_reg.len_ok         <= 1'b1;
            cfg_reg.ignore_case    <= 1'b0;
            cfg_reg.reverse_search <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/tpm_match_core.sv]
// pattern store, text window and parallel window compare
`default_nettype none

module tpm_match_core (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire tpm_pkg::cfg_t             cfg,
    input  wire logic                      advance,
    input  wire tpm_pkg::item_t            item,
    output logic                           found,
    output logic [tpm_pkg::COL_W-1:0]      match_column
);
    import tpm_pkg::*;

    logic [CHAR_W-1:0] pattern_reg [MAX_PATTERN];
    logic [CHAR_W-1:0] window_reg  [MAX_PATTERN];
    logic [CHAR_W-1:0] window_next [MAX_PATTERN];
    logic [LEN_W-1:0]  fill_reg;
    logic [LEN_W-1:0]  fill_next;
    logic [LEN_W-1:0]  fill_inc;

    logic [MAX_PATTERN*CHAR_W-1:0] rev_flat;
    logic [MAX_PATTERN*CHAR_W-1:0] aligned_flat;
    logic [MAX_PATTERN-1:0]        eq_vec;
    logic                          window_ok;
    logic [COL_W:0]                col_plus;
    logic [COL_W:0]                fwd_start;
    logic                          is_text;

    assign is_text = (item.action == ACT_TEXT);

    always_comb begin
        window_next[0] = item.char_code;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            window_next[k] = window_reg[k-1];
        end
        for (int j = 0; j < MAX_PATTERN; j++) begin
            rev_flat[j*CHAR_W +: CHAR_W] = window_next[MAX_PATTERN-1-j];
        end
    end

    // forward mode: pattern entry p meets window entry length-1-p
    assign aligned_flat = rev_flat >> {cfg.align_shift, 3'b000};

    always_comb begin
        for (int p = 0; p < MAX_PATTERN; p++) begin
            if (cfg.reverse_search) begin
                eq_vec[p] = fold_char(window_next[p], cfg.ignore_case) ==
                            fold_char(pattern_reg[p], cfg.ignore_case);
            end else begin
                eq_vec[p] = fold_char(aligned_flat[p*CHAR_W +: CHAR_W], cfg.ignore_case) ==
                            fold_char(pattern_reg[p], cfg.ignore_case);
            end
        end
        window_ok = &(eq_vec | ~cfg.len_mask);
    end

    assign fill_inc  = (fill_reg == LEN_W'(MAX_PATTERN)) ? fill_reg : fill_reg + LEN_W'(1);
    assign col_plus  = {1'b0, item.column} + (COL_W+1)'(1);
    assign fwd_start = col_plus - (COL_W+1)'(cfg.pattern_length);

    always_comb begin
        found        = 1'b0;
        match_column = '0;
        if (is_text && cfg.len_ok && (fill_inc >= cfg.pattern_length) && window_ok) begin
            if (cfg.reverse_search) begin
                found        = 1'b1;
                match_column = item.column;
            end else if (col_plus >= (COL_W+1)'(cfg.pattern_length)) begin
                found        = 1'b1;
                match_column = fwd_start[COL_W-1:0];
            end
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (advance) begin
            case (item.action)
                ACT_TEXT:  fill_next = fill_inc;
                ACT_CLEAR: fill_next = '0;
                default:   fill_next = fill_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // bytes beyond the fill count are never compared, so the window needs no reset
    always_ff @(posedge aclk) begin
        if (advance && is_text) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                window_reg[k] <= window_next[k];
            end
        end
        if (advance && (item.action == ACT_LOAD)) begin
            pattern_reg[item.pattern_index] <= item.char_code;
        end
    end

endmodule

`default_nettype wire

[rtl/text_pattern_matcher_top.sv]
// top level of the text pattern matcher: input register, match core, result register
//
// channel | dir | handshake             | content
// s_      | in  | s_tvalid / s_tready   | tuser action, tdata index/char/column
// m_      | out | m_tvalid / m_tready   | tuser found, tdata match column
// cfg_    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle sustained while m_tready is high; each item gives one result, registered
// in the input register and then the result register around the window compare
// reset clears pipeline valids and fill count and restores the default configuration; pattern store is not cleared
// a stalled result holds the pipeline; cfg_ready is always high
`default_nettype none

module text_pattern_matcher_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [tpm_pkg::IN_DATA_W-1:0]  s_tdata,   // pattern_index, char_code, column
    input  wire logic [tpm_pkg::ACT_W-1:0]      s_tuser,   // action
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [tpm_pkg::OUT_DATA_W-1:0]      m_tdata,   // match_column
    output logic                                m_tuser,   // found
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tpm_pkg::LEN_W-1:0]      cfg_data
);
    import tpm_pkg::*;

    cfg_t  cfg;
    item_t item_reg;
    logic  in_valid_reg;
    logic  out_valid_reg;
    logic  out_found_reg;
    logic [COL_W-1:0] out_col_reg;
    logic  advance;
    logic  out_free;
    logic  found;
    logic [COL_W-1:0] match_column;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    tpm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpm_match_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .advance      (advance),
        .item         (item_reg),
        .found        (found),
        .match_column (match_column)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.action        <= s_tuser;
            item_reg.pattern_index <= s_tdata[PAT_AW-1:0];
            item_reg.char_code     <= s_tdata[PAT_AW +: CHAR_W];
            item_reg.column        <= s_tdata[PAT_AW+CHAR_W +: COL_W];
        end
        if (advance) begin
            out_found_reg <= found;
            out_col_reg   <= match_column;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_col_reg;

endmodule

`default_nettype wire

[rtl/tpm_checker.sv]
// port-level checker for the text pattern matcher and its bind
`default_nettype none

module tpm_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [tpm_pkg::ACT_W-1:0]      s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [tpm_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic                           m_tuser
);
    import tpm_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_col_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("match column not zero without a match");

    a_non_text: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser != ACT_TEXT) ##1 m_tready |=> m_tvalid && !m_tuser)
        else $error("match reported for a non-text item");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind text_pattern_matcher_top tpm_checker u_tpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
